// ===== rtl/iff_pkg.sv =====
// ----------------------------------------------------------------------------
// iff_pkg: shared types and constants of the integer field formatter
// Holds the microcode ROM, the control word layout, the kind codes, the
// ASCII constants and the structs passed between the sequencer and the
// digit unit.
// ----------------------------------------------------------------------------
package iff_pkg;

   // Sizing
   localparam int MAX_WIDTH_DEF = 63;
   localparam int PTR_DIGITS    = 8;
   localparam int DEC_DIGITS    = 20;
   localparam int NIB_W         = 4 * DEC_DIGITS;
   localparam int DLEN_W        = 5;
   localparam int STEP_W        = 3;
   localparam int CONV_CNT_W    = 5;
   // double dabble handles four source bits per cycle
   localparam int CONV_STEPS_64 = 64 / 4;
   localparam int CONV_STEPS_32 = 32 / 4;

   // Kind codes
   localparam logic [2:0] KIND_SDEC = 3'd0;
   localparam logic [2:0] KIND_UDEC = 3'd1;
   localparam logic [2:0] KIND_HEXL = 3'd2;
   localparam logic [2:0] KIND_HEXU = 3'd3;

   // ASCII characters
   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_X     = 7'h78;
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_MINUS = 7'h2d;
   localparam logic [6:0] CH_PLUS  = 7'h2b;
   localparam logic [6:0] CH_UA    = 7'h41;
   localparam logic [6:0] CH_LA    = 7'h61;

   // Program addresses
   localparam logic [STEP_W-1:0] STEP_WAIT = 3'd0;
   localparam logic [STEP_W-1:0] STEP_CONV = 3'd1;
   localparam logic [STEP_W-1:0] STEP_MEAS = 3'd2;
   localparam logic [STEP_W-1:0] STEP_PFX  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_LEAD = 3'd4;
   localparam logic [STEP_W-1:0] STEP_SIGN = 3'd5;
   localparam logic [STEP_W-1:0] STEP_DIGS = 3'd6;
   localparam logic [STEP_W-1:0] STEP_TAIL = 3'd7;

   typedef enum logic [1:0] {
      OP_WAIT,
      OP_CONV,
      OP_MEAS,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      SEC_PFX,
      SEC_LEAD,
      SEC_SIGN,
      SEC_DIGS,
      SEC_TAIL
   } sec_type;

   // One control word: operation, output section, jump target when done
   typedef struct packed {
      op_type              op;
      sec_type             sec;
      logic [STEP_W-1:0]   nxt;
   } ucode_type;

   // Sequencer to digit unit
   typedef struct packed {
      logic                load;
      logic                step;
      logic [DLEN_W-1:0]   rd_idx;
   } dig_ctrl_type;

   // Digit unit to sequencer
   typedef struct packed {
      logic                conv_last;
      logic                nonzero;
      logic                neg;
      logic [DLEN_W-1:0]   dlen;
      logic [6:0]          digit_char;
   } dig_stat_type;

   // Microcode ROM
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         STEP_WAIT: w = '{op: OP_WAIT, sec: SEC_PFX,  nxt: STEP_CONV};
         STEP_CONV: w = '{op: OP_CONV, sec: SEC_PFX,  nxt: STEP_MEAS};
         STEP_MEAS: w = '{op: OP_MEAS, sec: SEC_PFX,  nxt: STEP_PFX};
         STEP_PFX:  w = '{op: OP_EMIT, sec: SEC_PFX,  nxt: STEP_LEAD};
         STEP_LEAD: w = '{op: OP_EMIT, sec: SEC_LEAD, nxt: STEP_SIGN};
         STEP_SIGN: w = '{op: OP_EMIT, sec: SEC_SIGN, nxt: STEP_DIGS};
         STEP_DIGS: w = '{op: OP_EMIT, sec: SEC_DIGS, nxt: STEP_TAIL};
         STEP_TAIL: w = '{op: OP_EMIT, sec: SEC_TAIL, nxt: STEP_WAIT};
         default:   w = '{op: OP_WAIT, sec: SEC_PFX,  nxt: STEP_CONV};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/iff_digit_unit.sv =====
// ----------------------------------------------------------------------------
// iff_digit_unit: argument conversion to a digit register
// Takes the magnitude of the argument, converts decimal kinds by double
// dabble four bits per cycle and hex kinds in one load, then reports the
// digit count and serves one digit character at a time.
// ----------------------------------------------------------------------------
module iff_digit_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  iff_pkg::dig_ctrl_type ctrl,
   input  logic [63:0]           value,
   input  logic [2:0]            kind,
   input  logic                  wide,
   output iff_pkg::dig_stat_type stat
);

   logic [63:0]                       src_ff, src_in;
   logic [iff_pkg::NIB_W-1:0]         digs_ff, digs_in;
   logic [iff_pkg::CONV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                              neg_ff, nz_ff, upper_ff;

   logic                              is_ptr, use64, is_dec, neg_c, upper_c;
   logic [63:0]                       v_c, nv_c, mag_c;
   logic [iff_pkg::NIB_W-1:0]         dab_d;
   logic [63:0]                       dab_s;
   logic [iff_pkg::DLEN_W-1:0]        dlen_c;
   logic [3:0]                        dsel;
   logic [6:0]                        dchar;
   logic                              iter;

   // Operand decode and magnitude
   always_comb begin
      is_ptr  = kind[2];
      use64   = wide && !is_ptr;
      is_dec  = (kind == iff_pkg::KIND_SDEC) || (kind == iff_pkg::KIND_UDEC);
      v_c     = use64 ? value : {32'b0, value[31:0]};
      nv_c    = 64'd0 - v_c;
      neg_c   = (kind == iff_pkg::KIND_SDEC) && (use64 ? v_c[63] : v_c[31]);
      mag_c   = neg_c ? (use64 ? nv_c : {32'b0, nv_c[31:0]}) : v_c;
      upper_c = is_ptr ? kind[0] : (kind == iff_pkg::KIND_HEXU);
   end

   // Four double dabble steps: adjust every digit, then shift one bit in
   always_comb begin
      dab_d = digs_ff;
      dab_s = src_ff;
      for (int b = 0; b < 4; b++) begin
         for (int i = 0; i < iff_pkg::DEC_DIGITS; i++) begin
            if (dab_d[4*i +: 4] >= 4'd5)
               dab_d[4*i +: 4] = dab_d[4*i +: 4] + 4'd3;
         end
         dab_d = {dab_d[iff_pkg::NIB_W-2:0], dab_s[63]};
         dab_s = {dab_s[62:0], 1'b0};
      end
   end

   // Next state
   always_comb begin
      iter    = ctrl.step && (cnt_ff != '0);
      cnt_in  = cnt_ff;
      src_in  = src_ff;
      digs_in = digs_ff;
      if (ctrl.load) begin
         if (is_dec)
            cnt_in = use64 ? iff_pkg::CONV_CNT_W'(iff_pkg::CONV_STEPS_64)
                           : iff_pkg::CONV_CNT_W'(iff_pkg::CONV_STEPS_32);
         else
            cnt_in = '0;
         src_in  = use64 ? mag_c : {mag_c[31:0], 32'b0};
         digs_in = is_dec ? '0 : {{(iff_pkg::NIB_W-64){1'b0}}, mag_c};
      end else if (iter) begin
         cnt_in  = cnt_ff - 1'b1;
         src_in  = dab_s;
         digs_in = dab_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      digs_ff <= digs_in;
      if (ctrl.load) begin
         neg_ff   <= neg_c;
         nz_ff    <= (v_c != 64'd0);
         upper_ff <= upper_c;
      end
   end

   // Significant digit count, at least one
   always_comb begin
      dlen_c = iff_pkg::DLEN_W'(1);
      for (int i = 0; i < iff_pkg::DEC_DIGITS; i++) begin
         if (digs_ff[4*i +: 4] != 4'd0)
            dlen_c = iff_pkg::DLEN_W'(i + 1);
      end
   end

   // Digit read and character map
   always_comb begin
      dsel = 4'd0;
      for (int i = 0; i < iff_pkg::DEC_DIGITS; i++) begin
         if (ctrl.rd_idx == iff_pkg::DLEN_W'(i))
            dsel = digs_ff[4*i +: 4];
      end
      if (dsel > 4'd9)
         dchar = (upper_ff ? iff_pkg::CH_UA : iff_pkg::CH_LA) + {3'b0, dsel} - 7'd10;
      else
         dchar = iff_pkg::CH_ZERO + {3'b0, dsel};
   end

   assign stat.conv_last  = (cnt_ff <= iff_pkg::CONV_CNT_W'(1));
   assign stat.nonzero    = nz_ff;
   assign stat.neg        = neg_ff;
   assign stat.dlen       = dlen_c;
   assign stat.digit_char = dchar;

endmodule

// ===== rtl/integer_field_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// integer_field_formatter_unit: printf style integer conversion
// Formats one integer request into a stream of characters, most significant
// first, with sign, "0x" prefix and padding; the final character is flagged.
//
//   channel | dir | ports                              | handshake
//   req     | in  | value kind wide flags field_width  | req_valid / req_stall
//   rsp     | out | char_out last                      | rsp_valid / rsp_stall
//
// The sequencer steps through wait, convert, measure and the five output
// sections (prefix, lead pad, sign, digits, tail pad). Decimal kinds are
// converted by the double dabble loop four bits per cycle, hex and pointer
// kinds at load. In a section, one character per cycle unless rsp_stall holds it.
// Reset is synchronous and returns the sequencer to its wait step.
// A stalled output holds the emit step; req_stall is low only in the wait step.
// ----------------------------------------------------------------------------
module integer_field_formatter_unit #(
   parameter int MAX_WIDTH = iff_pkg::MAX_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [63:0]  req_value,
   input  logic [2:0]   req_kind,
   input  logic         req_wide,
   input  logic         req_left_justify,
   input  logic         req_plus_sign,
   input  logic         req_zero_pad,
   input  logic         req_alternate,
   input  logic [5:0]   req_field_width,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [6:0]   rsp_char_out,
   output logic         rsp_last
);

   localparam int CW = $clog2(MAX_WIDTH + 1);

   iff_pkg::ucode_type                uc;
   iff_pkg::dig_ctrl_type             dctrl;
   iff_pkg::dig_stat_type             dstat;

   logic [iff_pkg::STEP_W-1:0]        step_ff, step_in;
   logic                              is_ptr_ff, left_ff, plus_ff, zpad_ff, alt_ff;
   logic [CW-1:0]                     wsat_ff;
   logic [1:0]                        pfx_ff, pfx_in;
   logic [CW-1:0]                     lead_ff, lead_in;
   logic                              sgn_ff, sgn_in;
   logic [iff_pkg::DLEN_W-1:0]        dcnt_ff, dcnt_in;
   logic [iff_pkg::DLEN_W-1:0]        idx_ff, idx_in;
   logic [CW-1:0]                     tail_ff, tail_in;
   logic [CW-1:0]                     total_ff, total_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [6:0]                        rsp_char_ff, rsp_char_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              accept, out_free, emit;
   logic [CW-1:0]                     sec_cnt;
   logic [6:0]                        sec_char;
   logic [CW-1:0]                     wsat_c, dlen_c, blen_c, pad_c, ptrl_c;
   logic [CW-1:0]                     lead_c, tail_c, total_c;
   logic                              sgn_c;
   logic [1:0]                        pfx_c;
   logic [8:0]                        fw9;

   // Control word fetch
   assign uc        = iff_pkg::ucode_rom(step_ff);
   assign req_stall = (uc.op != iff_pkg::OP_WAIT);
   assign accept    = req_valid && !req_stall;

   // Digit unit
   assign dctrl.load   = accept;
   assign dctrl.step   = (uc.op == iff_pkg::OP_CONV);
   assign dctrl.rd_idx = idx_ff;

   iff_digit_unit u_digits (
      .clock (clock),
      .reset (reset),
      .ctrl  (dctrl),
      .value (req_value),
      .kind  (req_kind),
      .wide  (req_wide),
      .stat  (dstat)
   );

   // Width saturation
   always_comb begin
      fw9    = {3'b0, req_field_width};
      wsat_c = (fw9 > 9'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(req_field_width);
   end

   // Section lengths
   always_comb begin
      dlen_c  = CW'(dstat.dlen);
      sgn_c   = !is_ptr_ff && dstat.nonzero && (dstat.neg || plus_ff);
      blen_c  = dlen_c + CW'(sgn_c);
      pad_c   = (wsat_ff > blen_c) ? (wsat_ff - blen_c) : '0;
      ptrl_c  = (CW'(iff_pkg::PTR_DIGITS) > dlen_c) ?
                (CW'(iff_pkg::PTR_DIGITS) - dlen_c) : '0;
      pfx_c   = (is_ptr_ff && alt_ff && dstat.nonzero) ? 2'd2 : 2'd0;
      lead_c  = is_ptr_ff ? ptrl_c : (left_ff ? '0 : pad_c);
      tail_c  = (!is_ptr_ff && left_ff) ? pad_c : '0;
      total_c = CW'(pfx_c) + lead_c + CW'(sgn_c) + dlen_c + tail_c;
   end

   // Current section count and character
   always_comb begin
      case (uc.sec)
         iff_pkg::SEC_PFX: begin
            sec_cnt  = CW'(pfx_ff);
            sec_char = (pfx_ff == 2'd2) ? iff_pkg::CH_ZERO : iff_pkg::CH_X;
         end
         iff_pkg::SEC_LEAD: begin
            sec_cnt  = lead_ff;
            sec_char = (is_ptr_ff || zpad_ff) ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE;
         end
         iff_pkg::SEC_SIGN: begin
            sec_cnt  = CW'(sgn_ff);
            sec_char = dstat.neg ? iff_pkg::CH_MINUS : iff_pkg::CH_PLUS;
         end
         iff_pkg::SEC_DIGS: begin
            sec_cnt  = CW'(dcnt_ff);
            sec_char = dstat.digit_char;
         end
         iff_pkg::SEC_TAIL: begin
            sec_cnt  = tail_ff;
            sec_char = iff_pkg::CH_SPACE;
         end
         default: begin
            sec_cnt  = '0;
            sec_char = iff_pkg::CH_SPACE;
         end
      endcase
      out_free = !rsp_valid_ff || !rsp_stall;
      emit     = (uc.op == iff_pkg::OP_EMIT) && (sec_cnt != '0) && out_free;
   end

   // Sequencer and counters
   always_comb begin
      step_in  = step_ff;
      pfx_in   = pfx_ff;
      lead_in  = lead_ff;
      sgn_in   = sgn_ff;
      dcnt_in  = dcnt_ff;
      idx_in   = idx_ff;
      tail_in  = tail_ff;
      total_in = total_ff;
      case (uc.op)
         iff_pkg::OP_WAIT: begin
            if (accept)
               step_in = uc.nxt;
         end
         iff_pkg::OP_CONV: begin
            if (dstat.conv_last)
               step_in = uc.nxt;
         end
         iff_pkg::OP_MEAS: begin
            step_in  = uc.nxt;
            pfx_in   = pfx_c;
            lead_in  = lead_c;
            sgn_in   = sgn_c;
            dcnt_in  = dstat.dlen;
            idx_in   = dstat.dlen - 1'b1;
            tail_in  = tail_c;
            total_in = total_c;
         end
         iff_pkg::OP_EMIT: begin
            if ((sec_cnt == '0) || (emit && (sec_cnt == CW'(1))))
               step_in = uc.nxt;
            if (emit) begin
               total_in = total_ff - 1'b1;
               case (uc.sec)
                  iff_pkg::SEC_PFX:  pfx_in  = pfx_ff - 1'b1;
                  iff_pkg::SEC_LEAD: lead_in = lead_ff - 1'b1;
                  iff_pkg::SEC_SIGN: sgn_in  = 1'b0;
                  iff_pkg::SEC_DIGS: begin
                     dcnt_in = dcnt_ff - 1'b1;
                     idx_in  = idx_ff - 1'b1;
                  end
                  iff_pkg::SEC_TAIL: tail_in = tail_ff - 1'b1;
                  default:           total_in = total_ff - 1'b1;
               endcase
            end
         end
         default: step_in = iff_pkg::STEP_WAIT;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = sec_char;
         rsp_last_in  = (total_ff == CW'(1));
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= iff_pkg::STEP_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pfx_ff      <= pfx_in;
      lead_ff     <= lead_in;
      sgn_ff      <= sgn_in;
      dcnt_ff     <= dcnt_in;
      idx_ff      <= idx_in;
      tail_ff     <= tail_in;
      total_ff    <= total_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (accept) begin
         is_ptr_ff <= req_kind[2];
         left_ff   <= req_left_justify;
         plus_ff   <= req_plus_sign;
         zpad_ff   <= req_zero_pad;
         alt_ff    <= req_alternate;
         wsat_ff   <= wsat_c;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== rtl/iff_checker.sv =====
// ----------------------------------------------------------------------------
// iff_checker: port level checks for the integer field formatter
// Watches the top level ports only and is attached by a bind below.
// ----------------------------------------------------------------------------
module iff_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input logic [6:0]   rsp_char_out,
   input logic         rsp_last
);

   // Output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_out) && $stable(rsp_last))
      else $error("stalled response changed");

   // Once a request is taken the block is busy converting
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one in flight");

   // Every character is printable
   a_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_out >= 7'h20) && (rsp_char_out <= 7'h7e))
      else $error("non printable character");

endmodule

bind integer_field_formatter_unit iff_checker u_iff_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_char_out (rsp_char_out),
   .rsp_last     (rsp_last)
);

// ===== sim/iff_stream_checker.sv =====
// ----------------------------------------------------------------------------
// iff_stream_checker: expected character stream for the integer formatter
// Watches the request and response channels of the formatter. Each accepted
// request is expanded into the characters it must produce. Each accepted
// character is then compared with the oldest one still expected, on both
// the character and the last flag.
// ----------------------------------------------------------------------------
module iff_stream_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  logic [63:0]  req_value,
   input  logic [2:0]   req_kind,
   input  logic         req_wide,
   input  logic         req_left_justify,
   input  logic         req_plus_sign,
   input  logic         req_zero_pad,
   input  logic         req_alternate,
   input  logic [5:0]   req_field_width,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  logic [6:0]   rsp_char_out,
   input  logic         rsp_last,
   output int unsigned  mismatch_count,
   output int unsigned  chars_pending,
   output int unsigned  chars_checked
);

   typedef struct {
      logic [6:0]    ch;
      logic          last;
      int unsigned   req_no;
   } fmt_char_type;

   fmt_char_type  expected_chars[$];
   fmt_char_type  oldest;
   int unsigned   requests_seen = 0;
   int unsigned   mismatch_total = 0;
   int unsigned   chars_total = 0;

   assign mismatch_count = mismatch_total;
   assign chars_checked  = chars_total;

   // one line per mismatch, and count it
   task automatic report_mismatch(input string what, input int unsigned req_no,
                                  input logic [7:0] got, input logic [7:0] want);
      mismatch_total++;
      $display("[%0t] request %0d: %s, got %h, expected %h",
               $time, req_no, what, got, want);
   endtask

   task automatic push_char(input logic [6:0] c);
      expected_chars.push_back('{ch: c, last: 1'b0, req_no: requests_seen});
   endtask

   // expand one request into its characters, most significant first
   task automatic format_request(input logic [63:0] value, input logic [2:0] kind,
                                 input logic wide, input logic left,
                                 input logic plus, input logic zpad,
                                 input logic alt, input logic [5:0] field_width);
      logic [63:0]   mag;
      logic [63:0]   base;
      logic [63:0]   rem;
      logic [6:0]    digs [0:23];
      logic          is_ptr;
      logic          hex;
      logic          upper;
      logic          neg;
      logic          nonzero;
      int unsigned   ndig;
      int unsigned   body_len;
      int unsigned   pad;
      int unsigned   width;
      int            i;
      // kinds 4..7 are pointers, odd ones upper case
      is_ptr = kind[2];
      hex    = is_ptr || (kind == iff_pkg::KIND_HEXL) || (kind == iff_pkg::KIND_HEXU);
      upper  = is_ptr ? kind[0] : (kind == iff_pkg::KIND_HEXU);
      width  = field_width;
      if (width > iff_pkg::MAX_WIDTH_DEF)
         width = iff_pkg::MAX_WIDTH_DEF;
      mag = (wide && !is_ptr) ? value : {32'h0, value[31:0]};
      nonzero = (mag != 64'd0);

      // only signed decimal turns a set sign bit into a minus sign
      neg = 1'b0;
      if (kind == iff_pkg::KIND_SDEC && (wide ? mag[63] : mag[31])) begin
         neg = 1'b1;
         mag = 64'd0 - mag;
         if (!wide)
            mag[63:32] = 32'h0;
      end

      // digits, least significant first; zero gives a single '0'
      base = hex ? 64'd16 : 64'd10;
      ndig = 0;
      do begin
         rem = mag % base;
         mag = mag / base;
         if (rem > 64'd9)
            digs[ndig] = (upper ? iff_pkg::CH_UA : iff_pkg::CH_LA) + 7'(rem - 64'd10);
         else
            digs[ndig] = iff_pkg::CH_ZERO + 7'(rem);
         ndig++;
      end while (mag != 64'd0);

      if (is_ptr) begin
         // optional prefix, then zero padded to a fixed digit count
         if (alt && nonzero) begin
            push_char(iff_pkg::CH_ZERO);
            push_char(iff_pkg::CH_X);
         end
         for (i = ndig; i < iff_pkg::PTR_DIGITS; i++)
            push_char(iff_pkg::CH_ZERO);
         for (i = ndig - 1; i >= 0; i--)
            push_char(digs[i]);
      end else begin
         body_len = ndig + ((nonzero && (neg || plus)) ? 1 : 0);
         pad = (width > body_len) ? width - body_len : 0;
         // leading pad comes before the sign, even when it is zeros
         if (!left)
            repeat (pad) push_char(zpad ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE);
         if (nonzero && neg)
            push_char(iff_pkg::CH_MINUS);
         else if (nonzero && plus)
            push_char(iff_pkg::CH_PLUS);
         for (i = ndig - 1; i >= 0; i--)
            push_char(digs[i]);
         if (left)
            repeat (pad) push_char(iff_pkg::CH_SPACE);
      end
      expected_chars[expected_chars.size() - 1].last = 1'b1;
   endtask

   // watch both channels at every edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            requests_seen++;
            format_request(req_value, req_kind, req_wide, req_left_justify,
                           req_plus_sign, req_zero_pad, req_alternate,
                           req_field_width);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("character with none expected", requests_seen,
                               {1'b0, rsp_char_out}, 8'h00);
            end else begin
               oldest = expected_chars.pop_front();
               chars_total++;
               if (rsp_char_out !== oldest.ch)
                  report_mismatch("char_out", oldest.req_no,
                                  {1'b0, rsp_char_out}, {1'b0, oldest.ch});
               if (rsp_last !== oldest.last)
                  report_mismatch("last", oldest.req_no,
                                  {7'h0, rsp_last}, {7'h0, oldest.last});
            end
         end
      end
      chars_pending <= expected_chars.size();
   end

endmodule

// ===== sim/tb_integer_field_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_integer_field_formatter_unit: testbench of the integer field formatter
// Sends a directed set of conversion requests (extremes, every kind, signs,
// padding and justification corners) and then random requests under three
// idle patterns on the two channels. A checker beside the block predicts
// every character and compares; this module only drives and gives a verdict.
// ----------------------------------------------------------------------------
module tb_integer_field_formatter_unit;

   // pointer kinds and the two unused codes that alias them
   localparam logic [2:0] KIND_PTRL     = 3'd4;
   localparam logic [2:0] KIND_PTRU     = 3'd5;
   localparam logic [2:0] KIND_PTRL_ALT = 3'd6;
   localparam logic [2:0] KIND_PTRU_ALT = 3'd7;
   localparam int unsigned RANDOM_PER_PHASE = 150;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [63:0]   req_value = 64'd0;
   logic [2:0]    req_kind = iff_pkg::KIND_SDEC;
   logic          req_wide = 1'b0;
   logic          req_left_justify = 1'b0;
   logic          req_plus_sign = 1'b0;
   logic          req_zero_pad = 1'b0;
   logic          req_alternate = 1'b0;
   logic [5:0]    req_field_width = 6'd0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [6:0]    rsp_char_out;
   logic          rsp_last;

   int unsigned   mismatch_count;
   int unsigned   chars_pending;
   int unsigned   chars_checked;
   int unsigned   sender_idle_pct = 17;
   int unsigned   receiver_idle_pct = 58;
   int unsigned   requests_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   integer_field_formatter_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_kind         (req_kind),
      .req_wide         (req_wide),
      .req_left_justify (req_left_justify),
      .req_plus_sign    (req_plus_sign),
      .req_zero_pad     (req_zero_pad),
      .req_alternate    (req_alternate),
      .req_field_width  (req_field_width),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_char_out     (rsp_char_out),
      .rsp_last         (rsp_last)
   );

   iff_stream_checker stream_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_kind         (req_kind),
      .req_wide         (req_wide),
      .req_left_justify (req_left_justify),
      .req_plus_sign    (req_plus_sign),
      .req_zero_pad     (req_zero_pad),
      .req_alternate    (req_alternate),
      .req_field_width  (req_field_width),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_char_out     (rsp_char_out),
      .rsp_last         (rsp_last),
      .mismatch_count   (mismatch_count),
      .chars_pending    (chars_pending),
      .chars_checked    (chars_checked)
   );

   // receiver stalls at random per cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // one request: random idle gap, then hold it until accepted
   task automatic send_request(input logic [63:0] value, input logic [2:0] kind,
                               input logic wide, input logic left,
                               input logic plus, input logic zpad,
                               input logic alt, input logic [5:0] width);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_value        <= value;
      req_kind         <= kind;
      req_wide         <= wide;
      req_left_justify <= left;
      req_plus_sign    <= plus;
      req_zero_pad     <= zpad;
      req_alternate    <= alt;
      req_field_width  <= width;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      requests_sent++;
   endtask

   // sender holds off until every expected character has come out
   task automatic drain_responses();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (chars_pending != 0);
   endtask

   // values leaning on zero, small magnitudes, sign bits and all ones
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(9))
         0: v = 64'd0;
         1: v = 64'($urandom_range(999));
         2: v = ~64'($urandom_range(999));
         3: v = {v[63:32], 32'h0};
         4: v = {v[63:32], 1'b1, 31'($urandom_range(999))};
         5: v = $urandom_range(1) ? 64'h8000_0000_0000_0000 : 64'hFFFF_FFFF_FFFF_FFFF;
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_random();
      logic [2:0] kind;
      logic [5:0] width;
      if ($urandom_range(9) == 0)
         kind = $urandom_range(1) ? KIND_PTRL_ALT : KIND_PTRU_ALT;
      else
         kind = 3'($urandom_range(5));
      if ($urandom_range(3) == 0)
         width = 6'($urandom_range(63));
      else
         width = 6'($urandom_range(12));
      send_request(random_value(), kind, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), width);
   endtask

   // stimulus and verdict
   initial begin
      int unsigned wait_cycles;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: value, kind, wide, left, plus, zpad, alt, width
      send_request(64'd0, iff_pkg::KIND_SDEC, 1, 0, 1, 1, 1, 6'd5);
      send_request(64'h1234_5678_FFFF_FFFB, iff_pkg::KIND_SDEC, 0, 0, 0, 1, 0, 6'd4);
      send_request(64'h8000_0000_0000_0000, iff_pkg::KIND_SDEC, 1, 0, 1, 0, 0, 6'd0);
      send_request(64'hDEAD_BEEF_8000_0000, iff_pkg::KIND_SDEC, 0, 0, 0, 0, 0, 6'd12);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, iff_pkg::KIND_UDEC, 1, 0, 1, 0, 0, 6'd25);
      send_request(64'hA5A5_A5A5_FFFF_FFFF, iff_pkg::KIND_UDEC, 0, 1, 0, 1, 0, 6'd14);
      send_request(64'hDEAD_BEEF_0123_4567, iff_pkg::KIND_HEXL, 1, 0, 1, 0, 1, 6'd0);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, iff_pkg::KIND_HEXU, 1, 1, 0, 0, 0, 6'd20);
      send_request(64'h0000_0000_FEDC_BA98, iff_pkg::KIND_HEXL, 0, 0, 0, 1, 0, 6'd10);
      send_request(64'hFFFF_FFFF_0000_0ABC, KIND_PTRL, 1, 1, 1, 1, 1, 6'd63);
      send_request(64'hFFFF_FFFF_0000_0000, KIND_PTRU, 1, 0, 1, 1, 1, 6'd30);
      send_request(64'h1234_5678_9ABC_DEF0, KIND_PTRL_ALT, 0, 0, 0, 0, 1, 6'd3);
      send_request(64'h0000_0000_CAFE_F00D, KIND_PTRU_ALT, 0, 0, 0, 0, 0, 6'd0);
      send_request(64'h0000_0000_FFFF_FFFF, iff_pkg::KIND_SDEC, 0, 1, 0, 1, 0, 6'd63);
      send_request(64'd1, iff_pkg::KIND_UDEC, 1, 0, 0, 0, 0, 6'd63);
      send_request(64'd42, iff_pkg::KIND_SDEC, 0, 0, 1, 1, 0, 6'd6);
      send_request(64'd0, iff_pkg::KIND_UDEC, 0, 0, 0, 0, 0, 6'd0);
      send_request(64'd123456, iff_pkg::KIND_UDEC, 0, 0, 0, 1, 0, 6'd1);
      send_request(64'd0, iff_pkg::KIND_UDEC, 1, 1, 1, 0, 0, 6'd2);
      send_request(64'h0000_0000_7FFF_FFFF, iff_pkg::KIND_SDEC, 0, 0, 1, 0, 0, 6'd0);
      send_request(64'h7FFF_FFFF_FFFF_FFFF, iff_pkg::KIND_SDEC, 1, 1, 1, 0, 0, 6'd25);
      send_request(64'd0, iff_pkg::KIND_HEXU, 0, 0, 1, 0, 1, 6'd3);
      send_request(64'h0000_0000_0000_00FF, iff_pkg::KIND_HEXU, 0, 0, 1, 1, 0, 6'd5);
      drain_responses();

      // random, sender idles less than receiver
      repeat (RANDOM_PER_PHASE) send_random();

      // random, roles swapped
      sender_idle_pct   = 58;
      receiver_idle_pct = 17;
      repeat (RANDOM_PER_PHASE) send_random();
      drain_responses();

      // random, no idling on either side
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      repeat (RANDOM_PER_PHASE) send_random();
      req_valid <= 1'b0;

      // let the output drain, then give late extra characters a chance
      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while (chars_pending != 0 && wait_cycles < 20000);
      repeat (100) @(posedge clock);

      if (chars_pending != 0)
         $display("%0d expected characters never came out", chars_pending);
      $display("Covered %0d requests: all kinds, signs, both sizes, widths 0 to 63,",
               requests_sent);
      $display("three idle patterns; %0d characters compared.", chars_checked);
      if (mismatch_count == 0 && chars_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #5000000;
      $display("Timeout: formatter stopped making progress");
      $display("Regression FAIL");
      $finish;
   end

endmodule
